/* rtl/core/ils_pkg.sv */
`default_nettype none

package ils_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 7;
    localparam int LEN_W        = 7;
    localparam int OP_W         = 3;
    localparam int ST_W         = 2;
    localparam int ILS_CAPACITY = 64;

    typedef enum logic [OP_W-1:0] {
        OP_GET       = 3'd0,
        OP_ADD_HEAD  = 3'd1,
        OP_ADD_TAIL  = 3'd2,
        OP_ADD_INDEX = 3'd3,
        OP_DELETE    = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_GET,
        KIND_INS,
        KIND_DEL
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_STEP,
        S_INS_MOVE,
        S_DEL_STEP,
        S_DEL_MOVE,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        RA_TARGET,
        RA_BELOW,
        RA_ABOVE
    } rd_sel_t;

    typedef enum logic {
        WR_VALUE,
        WR_SHIFT
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    cursor_dec;
        logic    cursor_inc;
        logic    finish;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  ok;
        logic  at_target;
        logic  at_last;
        logic  out_free;
    } stat_t;

endpackage

`default_nettype wire

/* rtl/core/indexed_list_store.sv */
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit entries held in one RAM with a
// single write port and a registered read port. Each request beat (get, insert
// at head, tail or position, delete at position) returns exactly one result
// beat carrying the read value, a status (done, position out of range, list
// full) and the list length afterwards. Requests are handled one at a time:
// a get reads the target entry, an insert moves the entries at and above the
// insert position up one place, top first, then writes the value, and a delete
// moves the entries above the position down one place; each moved entry costs
// one RAM read and one RAM write. A new request is taken once the previous
// result is loaded into the output register, even if it has not been taken yet.
module indexed_list_store
    import ils_pkg::*;
#(
    parameter int CAPACITY = ILS_CAPACITY
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [OP_W-1:0]          s_operation,
    input  wire logic [POS_W-1:0]         s_position,
    input  wire logic signed [DATA_W-1:0] s_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [DATA_W-1:0]      m_read_value,
    output logic [ST_W-1:0]               m_status,
    output logic [LEN_W-1:0]              m_length
);

    cmd_t  cmd;
    stat_t stat;

    ils_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ils_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_operation  (s_operation),
        .s_position   (s_position),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_length     (m_length),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

`default_nettype wire

/* rtl/core/ils_ram.sv */
`default_nettype none

module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/ils_ctrl.sv */
`default_nettype none

module ils_ctrl
    import ils_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RA_TARGET;
        cmd.wr_sel = WR_VALUE;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!stat.ok) begin
                    state_next = S_FINISH;
                end else begin
                    case (stat.kind)
                        KIND_GET: begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RA_TARGET;
                            state_next = S_FINISH;
                        end
                        KIND_INS: state_next = S_INS_STEP;
                        KIND_DEL: state_next = S_DEL_STEP;
                        default:  state_next = S_FINISH;
                    endcase
                end
            end
            S_INS_STEP: begin
                if (stat.at_target) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_VALUE;
                    state_next = S_FINISH;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_BELOW;
                    state_next = S_INS_MOVE;
                end
            end
            S_INS_MOVE: begin
                cmd.wr_en      = 1'b1;
                cmd.wr_sel     = WR_SHIFT;
                cmd.cursor_dec = 1'b1;
                state_next     = S_INS_STEP;
            end
            S_DEL_STEP: begin
                if (stat.at_last) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_ABOVE;
                    state_next = S_DEL_MOVE;
                end
            end
            S_DEL_MOVE: begin
                cmd.wr_en      = 1'b1;
                cmd.wr_sel     = WR_SHIFT;
                cmd.cursor_inc = 1'b1;
                state_next     = S_DEL_STEP;
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/ils_datapath.sv */
`default_nettype none

module ils_datapath
    import ils_pkg::*;
#(
    parameter int CAPACITY = ILS_CAPACITY
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [OP_W-1:0]          s_operation,
    input  wire logic [POS_W-1:0]         s_position,
    input  wire logic signed [DATA_W-1:0] s_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [DATA_W-1:0]      m_read_value,
    output logic [ST_W-1:0]               m_status,
    output logic [LEN_W-1:0]              m_length,
    input  wire cmd_t                     cmd,
    output stat_t                         stat
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]     count_reg,  count_next;
    logic [AW-1:0]     cursor_reg, cursor_next;
    logic [AW-1:0]     target_reg, target_next;
    kind_t             kind_reg,   kind_next;
    logic              ok_reg,     ok_next;
    status_t           status_reg, status_next;
    logic [DATA_W-1:0] val_reg,    val_next;

    logic              m_valid_reg,      m_valid_next;
    logic [DATA_W-1:0] m_read_value_reg, m_read_value_next;
    logic [ST_W-1:0]   m_status_reg,     m_status_next;
    logic [LEN_W-1:0]  m_length_reg,     m_length_next;

    kind_t             dec_kind;
    logic              dec_ok;
    status_t           dec_status;
    logic [AW-1:0]     dec_target;
    logic [AW-1:0]     dec_cursor;
    logic [PW-1:0]     pos_ext;
    logic [PW-1:0]     cnt_ext;
    logic [PW-1:0]     ins_pos;
    logic              full;

    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;
    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;

    always_comb begin
        pos_ext    = PW'(s_position);
        cnt_ext    = PW'(count_reg);
        full       = (count_reg == CW'(CAPACITY));
        ins_pos    = '0;
        dec_kind   = KIND_NONE;
        dec_ok     = 1'b0;
        dec_status = ST_DONE;
        dec_target = AW'(s_position);
        dec_cursor = AW'(count_reg);
        case (op_t'(s_operation))
            OP_GET: begin
                dec_kind = KIND_GET;
                dec_ok   = pos_ext < cnt_ext;
            end
            OP_ADD_HEAD: begin
                dec_kind = KIND_INS;
                ins_pos  = '0;
            end
            OP_ADD_TAIL: begin
                dec_kind = KIND_INS;
                ins_pos  = cnt_ext;
            end
            OP_ADD_INDEX: begin
                dec_kind = KIND_INS;
                ins_pos  = pos_ext;
            end
            OP_DELETE: begin
                dec_kind   = KIND_DEL;
                dec_ok     = pos_ext < cnt_ext;
                dec_cursor = AW'(s_position);
            end
            default: dec_kind = KIND_NONE;
        endcase
        if (dec_kind == KIND_INS) begin
            dec_target = AW'(ins_pos);
            if (ins_pos > cnt_ext) begin
                dec_status = ST_RANGE;
            end else if (full) begin
                dec_status = ST_FULL;
            end else begin
                dec_ok = 1'b1;
            end
        end else if ((dec_kind == KIND_GET || dec_kind == KIND_DEL) && !dec_ok) begin
            dec_status = ST_RANGE;
        end
    end

    always_comb begin
        kind_next   = kind_reg;
        ok_next     = ok_reg;
        status_next = status_reg;
        target_next = target_reg;
        cursor_next = cursor_reg;
        val_next    = val_reg;
        count_next  = count_reg;
        if (cmd.load) begin
            kind_next   = dec_kind;
            ok_next     = dec_ok;
            status_next = dec_status;
            target_next = dec_target;
            cursor_next = dec_cursor;
            val_next    = s_value;
        end else if (cmd.cursor_dec) begin
            cursor_next = cursor_reg - AW'(1);
        end else if (cmd.cursor_inc) begin
            cursor_next = cursor_reg + AW'(1);
        end
        if (cmd.finish && ok_reg) begin
            if (kind_reg == KIND_INS) begin
                count_next = count_reg + CW'(1);
            end else if (kind_reg == KIND_DEL) begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    always_comb begin
        m_valid_next      = m_valid_reg;
        m_read_value_next = m_read_value_reg;
        m_status_next     = m_status_reg;
        m_length_next     = m_length_reg;
        if (cmd.finish) begin
            m_valid_next  = 1'b1;
            m_status_next = status_reg;
            m_length_next = LEN_W'(count_next);
            if (kind_reg == KIND_GET) begin
                m_read_value_next = ok_reg ? ram_rd_data : '1;
            end else begin
                m_read_value_next = '0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            kind_reg    <= KIND_NONE;
            ok_reg      <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            kind_reg    <= kind_next;
            ok_reg      <= ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg       <= status_next;
        target_reg       <= target_next;
        cursor_reg       <= cursor_next;
        val_reg          <= val_next;
        m_read_value_reg <= m_read_value_next;
        m_status_reg     <= m_status_next;
        m_length_reg     <= m_length_next;
    end

    always_comb begin
        ram_rd_en = cmd.rd_en;
        case (cmd.rd_sel)
            RA_TARGET: ram_rd_addr = target_reg;
            RA_BELOW:  ram_rd_addr = cursor_reg - AW'(1);
            RA_ABOVE:  ram_rd_addr = cursor_reg + AW'(1);
            default:   ram_rd_addr = target_reg;
        endcase
        ram_wr_en = cmd.wr_en;
        if (cmd.wr_sel == WR_VALUE) begin
            ram_wr_addr = target_reg;
            ram_wr_data = val_reg;
        end else begin
            ram_wr_addr = cursor_reg;
            ram_wr_data = ram_rd_data;
        end
    end

    ils_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign stat.kind      = kind_reg;
    assign stat.ok        = ok_reg;
    assign stat.at_target = (cursor_reg == target_reg);
    assign stat.at_last   = ((CW'(cursor_reg) + CW'(1)) == count_reg);
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_status     = m_status_reg;
    assign m_length     = m_length_reg;

endmodule

`default_nettype wire

/* rtl/core/ils_checker.sv */
`default_nettype none

module ils_checker
    import ils_pkg::*;
#(
    parameter int CAPACITY = ILS_CAPACITY
) (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_valid,
    input wire logic                     s_ready,
    input wire logic [OP_W-1:0]          s_operation,
    input wire logic [POS_W-1:0]         s_position,
    input wire logic signed [DATA_W-1:0] s_value,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic signed [DATA_W-1:0] m_read_value,
    input wire logic [ST_W-1:0]          m_status,
    input wire logic [LEN_W-1:0]         m_length
);

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while previous one in flight");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_value)
            && $stable(m_status) && $stable(m_length))
        else $error("stalled result beat changed");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_DONE || m_status == ST_RANGE
            || m_status == ST_FULL))
        else $error("illegal status code");

    a_full_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> m_length == LEN_W'(CAPACITY)
            && m_read_value == '0)
        else $error("full status with wrong length or value");

    a_range_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_RANGE |-> m_read_value == '0 || m_read_value == '1)
        else $error("range status with unexpected read value");

endmodule

bind indexed_list_store ils_checker #(.CAPACITY(CAPACITY)) u_ils_checker (.*);

`default_nettype wire
